@@ src/rv32_exec_pkg.sv @@
// Package for the RV32IM execute unit: field widths, opcodes, outcome codes, item and result structs,
// controller command and status structs. Depends on nothing.
`timescale 1ns / 1ps
package rv32_exec_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned RIDX_W    = 5;

  // Major opcodes.
  localparam logic [6:0] OP_SYSTEM = 7'h73;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;

  localparam logic [6:0] F7_ZERO = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MULD = 7'h01;

  // Host service codes in a7.
  localparam logic [XLEN-1:0] SVC_GETCHAR = 32'd1;
  localparam logic [XLEN-1:0] SVC_PUTCHAR = 32'd2;
  localparam logic [RIDX_W-1:0] REG_A0 = 5'd10;
  localparam logic [RIDX_W-1:0] REG_A7 = 5'd17;
  localparam logic [2:0] EXT_WORD = 3'd2;

  typedef enum logic [2:0] {
    OC_RETIRED  = 3'd0,
    OC_LOAD     = 3'd1,
    OC_STORE    = 3'd2,
    OC_ECALL    = 3'd3,
    OC_ILLEGAL  = 3'd4,
    OC_RESPONSE = 3'd5
  } outcome_t;

  typedef struct packed {
    logic [2:0]      outcome;
    logic [XLEN-1:0] mem_address;
    logic [XLEN-1:0] store_value;
    logic [1:0]      access_size;
    logic [XLEN-1:0] next_pc;
    logic [XLEN-1:0] ecall_code;
    logic [XLEN-1:0] ecall_arg;
  } result_t;

  typedef struct packed {
    logic            mode;
    logic [XLEN-1:0] instruction;
    logic [XLEN-1:0] response_data;
  } item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic rd_regs;   // read register file for the held item
    logic exec;      // compute and commit the held item
    logic div_start; // start the divider
    logic div_step;  // one divider iteration
    logic div_fin;   // commit the divider result
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic needs_div;
    logic div_done;
  } dp_sts_t;

endpackage

@@ src/rv32_exec_if.sv @@
// Valid/ready channel interface used by all ports of the execute unit.
// Depends on nothing; payload type is a parameter.
`timescale 1ns / 1ps
interface rv32_exec_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/rv32im_instruction_execute_unit.sv @@
// Top level of the RV32IM execute unit: channel interfaces, controller and datapath.
// Depends on rv32_exec_pkg, rv32_exec_if, rv32_exec_ctrl, rv32_exec_dp.
//
// Channel | Direction | Payload
// in_     | sink      | mode, instruction, response_data
// out_    | source    | outcome, mem_address, store_value, access_size, next_pc,
//         |           | ecall_code, ecall_arg
// cfg_    | sink      | start_address (loads pc too)
//
// An item passes through register file read and execute states before the result is valid,
// and MUL-unit divides and remainders also pass through the restoring divider, which does one bit per cycle.
// One item is in flight; the next beat is taken after the result beat leaves.
// Synchronous active-low reset clears pc, pending-load state and register valid bits.
// A stalled output holds the result and the input stays not ready.
`timescale 1ns / 1ps
module rv32im_instruction_execute_unit (
  input logic clk,
  input logic rst_n,
  rv32_exec_if.sink   in_ch,
  rv32_exec_if.source out_ch,
  rv32_exec_if.sink   cfg_ch
);
  import rv32_exec_pkg::*;

  logic    load_item;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  rv32_exec_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .load_item(load_item), .cmd(cmd), .sts(sts)
  );

  rv32_exec_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .load_item(load_item), .item_in(in_ch.data),
    .cfg_we(cfg_ch.valid), .cfg_data(cfg_ch.data),
    .cmd(cmd), .sts(sts), .res(out_ch.data)
  );
endmodule

@@ src/rv32_ram.sv @@
// Generic single-write, two-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module rv32_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end
endmodule

@@ src/rv32_exec_ctrl.sv @@
// Controller state machine of the execute unit: sequences read, execute,
// divide and output. Depends on rv32_exec_pkg.
`timescale 1ns / 1ps
module rv32_exec_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   load_item,
  output rv32_exec_pkg::dp_cmd_t cmd,
  input  rv32_exec_pkg::dp_sts_t sts
);
  import rv32_exec_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_EXEC = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign load_item = in_valid && in_ready;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_READ;
      S_READ: begin
        cmd.rd_regs = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.needs_div) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          cmd.exec = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_fin = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // One item in flight: no new beat while a result is held.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input accepted while result held");
  a_exec_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid) else $error("execute did not reach output");
  a_div_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_fin |=> out_valid) else $error("divide did not reach output");
endmodule

@@ src/rv32_exec_dp.sv @@
// Datapath of the execute unit: register file RAM, pc, pending-load state,
// ALU, multiplier, restoring divider and result register. Depends on rv32_exec_pkg, rv32_ram.
`timescale 1ns / 1ps
module rv32_exec_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load_item,
  input  rv32_exec_pkg::item_t        item_in,
  input  logic                        cfg_we,
  input  logic [31:0]                 cfg_data,
  input  rv32_exec_pkg::dp_cmd_t      cmd,
  output rv32_exec_pkg::dp_sts_t      sts,
  output rv32_exec_pkg::result_t      res
);
  import rv32_exec_pkg::*;

  item_t            item_r;
  logic [XLEN-1:0]  pc_r, pc_nxt;
  logic [RIDX_W-1:0] pend_dest_r;
  logic [2:0]       pend_ext_r;
  logic             await_r;
  logic [REG_COUNT-1:0] valid_r;   // entries written since reset
  result_t          res_r, res_nxt;

  // Register file RAM; the held item's registers are read in the read state.
  logic             rf_we;
  logic [RIDX_W-1:0] rf_waddr;
  logic [XLEN-1:0]  rf_wdata, rf_a_raw, rf_b_raw;
  logic [RIDX_W-1:0] ra_sel, rb_sel;
  logic [RIDX_W-1:0] ra_hold_r, rb_hold_r;

  // System reads a7/a0, everything else rs1/rs2.
  always_comb begin
    if (item_r.instruction[6:0] == OP_SYSTEM) begin
      ra_sel = REG_A7;
      rb_sel = REG_A0;
    end else begin
      ra_sel = item_r.instruction[19:15];
      rb_sel = item_r.instruction[24:20];
    end
  end

  rv32_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr_a(ra_sel), .raddr_b(rb_sel), .rdata_a(rf_a_raw), .rdata_b(rf_b_raw)
  );

  always_ff @(posedge clk) begin
    if (cmd.rd_regs) begin
      ra_hold_r <= ra_sel;
      rb_hold_r <= rb_sel;
    end
  end

  logic [XLEN-1:0] a, b;
  assign a = (ra_hold_r == '0 || !valid_r[ra_hold_r]) ? '0 : rf_a_raw;
  assign b = (rb_hold_r == '0 || !valid_r[rb_hold_r]) ? '0 : rf_b_raw;

  // Instruction fields.
  logic [31:0] w;
  logic [6:0]  op, f7;
  logic [2:0]  f3;
  logic [4:0]  rd;
  logic [31:0] immi, imms, immb, immj, immu;
  assign w    = item_r.instruction;
  assign op   = w[6:0];
  assign rd   = w[11:7];
  assign f3   = w[14:12];
  assign f7   = w[31:25];
  assign immi = {{20{w[31]}}, w[31:20]};
  assign imms = {{20{w[31]}}, w[31:25], w[11:7]};
  assign immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign immu = {w[31:12], 12'd0};

  logic is_muldiv, is_div;
  assign is_muldiv = (op == OP_REG) && (f7 == F7_MULD);
  assign is_div    = is_muldiv && f3[2];
  assign sts.needs_div = is_div && (item_r.mode == 1'b0);

  // Multiplier: one 33x33 signed product per item.
  logic signed [32:0] ma, mb;
  logic signed [65:0] mprod;
  assign ma = {(f3 == 3'd1 || f3 == 3'd2) ? a[31] : 1'b0, a};
  assign mb = {(f3 == 3'd1) ? b[31] : 1'b0, b};
  assign mprod = ma * mb;

  // Base ALU; b_op is the second operand for the immediate or register form.
  logic [31:0] b_op, alu_y;
  logic        alu_ok, alt;
  always_comb begin
    b_op = (op == OP_IMM) ? ((f3 == 3'd1 || f3 == 3'd5) ? {27'd0, w[24:20]} : immi) : b;
    alt  = (op == OP_REG || f3 == 3'd5) && (f7 == F7_ALT);
    alu_ok = 1'b1;
    alu_y  = '0;
    case (f3)
      3'd1: begin
        alu_ok = (f7 == F7_ZERO) || (op == OP_IMM ? 1'b0 : 1'b0);
        alu_y  = a << b_op[4:0];
      end
      3'd5: begin
        alu_ok = (f7 == F7_ZERO) || (f7 == F7_ALT);
        alu_y  = alt ? 32'($signed(a) >>> b_op[4:0]) : a >> b_op[4:0];
      end
      3'd0: alu_y = (op == OP_REG && f7 == F7_ALT) ? a - b_op : a + b_op;
      3'd2: alu_y = {31'd0, $signed(a) < $signed(b_op)};
      3'd3: alu_y = {31'd0, a < b_op};
      3'd4: alu_y = a ^ b_op;
      3'd6: alu_y = a | b_op;
      default: alu_y = a & b_op;
    endcase
    if (op == OP_REG && f3 != 3'd1 && f3 != 3'd5)
      alu_ok = (f7 == F7_ZERO) || (f7 == F7_ALT && f3 == 3'd0);
  end

  // Restoring divider on magnitudes, one quotient bit per cycle.
  logic [31:0] dv_q_r, dv_rem_r, dv_d_r, dv_a_r;
  logic [5:0]  dv_cnt_r;
  logic        dv_negq_r, dv_negr_r, dv_zero_r, dv_ovf_r, dv_rem_sel_r;
  logic [32:0] dv_trial;
  logic [31:0] dv_shift;
  assign dv_shift = {dv_rem_r[30:0], dv_q_r[31]};
  assign dv_trial = {1'b0, dv_shift} - {1'b0, dv_d_r};
  assign sts.div_done = (dv_cnt_r == 6'd32);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dv_rem_sel_r <= f3[1];
      dv_a_r       <= a;
      dv_zero_r    <= (b == '0);
      dv_ovf_r     <= !f3[0] && a == 32'h8000_0000 && b == '1;
      dv_negq_r    <= !f3[0] && (a[31] ^ b[31]);
      dv_negr_r    <= !f3[0] && a[31];
      dv_q_r       <= (!f3[0] && a[31]) ? -a : a;
      dv_d_r       <= (!f3[0] && b[31]) ? -b : b;
      dv_rem_r     <= '0;
      dv_cnt_r     <= '0;
    end else if (cmd.div_step) begin
      dv_cnt_r <= dv_cnt_r + 6'd1;
      if (!dv_trial[32]) begin
        dv_rem_r <= dv_trial[31:0];
        dv_q_r   <= {dv_q_r[30:0], 1'b1};
      end else begin
        dv_rem_r <= dv_shift;
        dv_q_r   <= {dv_q_r[30:0], 1'b0};
      end
    end
  end

  logic [31:0] div_y;
  always_comb begin
    if (dv_rem_sel_r) begin
      if (dv_zero_r)     div_y = dv_a_r;
      else if (dv_ovf_r) div_y = '0;
      else               div_y = dv_negr_r ? -dv_rem_r : dv_rem_r;
    end else begin
      if (dv_zero_r)     div_y = '1;
      else if (dv_ovf_r) div_y = 32'h8000_0000;
      else               div_y = dv_negq_r ? -dv_q_r : dv_q_r;
    end
  end

  // Response extension.
  logic [31:0] resp_v;
  always_comb begin
    case (pend_ext_r)
      3'd0:    resp_v = {{24{item_r.response_data[7]}}, item_r.response_data[7:0]};
      3'd1:    resp_v = {{16{item_r.response_data[15]}}, item_r.response_data[15:0]};
      3'd4:    resp_v = {24'd0, item_r.response_data[7:0]};
      3'd5:    resp_v = {16'd0, item_r.response_data[15:0]};
      default: resp_v = item_r.response_data;
    endcase
  end

  // Execute: result, register write and state updates.
  logic [31:0] npc4, wb_val;
  logic        wb_en, take, set_pend;
  logic [4:0]  wb_idx, set_dest;
  logic [2:0]  set_ext;
  logic        clr_pend;
  always_comb begin
    npc4 = pc_r + 32'd4;
    res_nxt = '0;
    res_nxt.outcome = OC_RETIRED;
    res_nxt.next_pc = pc_r;
    pc_nxt = pc_r;
    wb_en = 1'b0;
    wb_idx = rd;
    wb_val = '0;
    set_pend = 1'b0;
    set_dest = rd;
    set_ext = f3;
    clr_pend = 1'b0;
    take = 1'b0;
    if (item_r.mode) begin
      if (!await_r) begin
        res_nxt.outcome = OC_ILLEGAL;
      end else begin
        res_nxt.outcome = OC_RESPONSE;
        wb_en = 1'b1;
        wb_idx = pend_dest_r;
        wb_val = resp_v;
        clr_pend = 1'b1;
      end
    end else begin
      unique case (op)
        OP_SYSTEM: begin
          res_nxt.outcome = OC_ECALL;
          res_nxt.ecall_code = a;
          res_nxt.ecall_arg = b;
          if (a == SVC_GETCHAR) begin
            set_pend = 1'b1;
            set_dest = REG_A0;
            set_ext = EXT_WORD;
            pc_nxt = npc4;
          end else if (a == SVC_PUTCHAR) begin
            pc_nxt = npc4;
          end
        end
        OP_LUI: begin wb_en = 1'b1; wb_val = immu; pc_nxt = npc4; end
        OP_AUIPC: begin wb_en = 1'b1; wb_val = pc_r + immu; pc_nxt = npc4; end
        OP_JAL: begin wb_en = 1'b1; wb_val = npc4; pc_nxt = pc_r + immj; end
        OP_JALR: begin
          wb_en = 1'b1; wb_val = npc4;
          pc_nxt = (a + immi) & ~32'd1;
        end
        OP_BRANCH: begin
          case (f3)
            3'd0: take = (a == b);
            3'd1: take = (a != b);
            3'd4: take = $signed(a) < $signed(b);
            3'd5: take = !($signed(a) < $signed(b));
            3'd6: take = a < b;
            3'd7: take = a >= b;
            default: res_nxt.outcome = OC_ILLEGAL;
          endcase
          if (f3 != 3'd2 && f3 != 3'd3) pc_nxt = take ? pc_r + immb : npc4;
        end
        OP_LOAD: begin
          if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) begin
            res_nxt.outcome = OC_ILLEGAL;
          end else begin
            res_nxt.outcome = OC_LOAD;
            res_nxt.mem_address = a + immi;
            res_nxt.access_size = f3[1:0];
            set_pend = 1'b1;
            pc_nxt = npc4;
          end
        end
        OP_STORE: begin
          if (f3 > 3'd2) begin
            res_nxt.outcome = OC_ILLEGAL;
          end else begin
            res_nxt.outcome = OC_STORE;
            res_nxt.mem_address = a + imms;
            res_nxt.access_size = f3[1:0];
            res_nxt.store_value = (f3 == 3'd0) ? {24'd0, b[7:0]} :
                                  (f3 == 3'd1) ? {16'd0, b[15:0]} : b;
            pc_nxt = npc4;
          end
        end
        OP_IMM, OP_REG: begin
          if (is_muldiv) begin
            wb_en = 1'b1;
            wb_val = (f3 == 3'd0) ? mprod[31:0] : mprod[63:32];
            pc_nxt = npc4;
          end else if (alu_ok) begin
            wb_en = 1'b1; wb_val = alu_y; pc_nxt = npc4;
          end else begin
            res_nxt.outcome = OC_ILLEGAL;
          end
        end
        default: res_nxt.outcome = OC_ILLEGAL;
      endcase
    end
    if (cmd.div_fin) begin
      pc_nxt = npc4;
      wb_en = 1'b1;
      wb_val = div_y;
      set_pend = 1'b0;
      clr_pend = 1'b0;
      res_nxt.outcome = OC_RETIRED;
    end
    res_nxt.next_pc = pc_nxt;
  end

  logic commit;
  assign commit   = cmd.exec || cmd.div_fin;
  assign rf_we    = commit && wb_en && (wb_idx != '0);
  assign rf_waddr = wb_idx;
  assign rf_wdata = wb_val;

  always_ff @(posedge clk) begin
    if (load_item) item_r <= item_in;
    if (commit) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      pend_dest_r <= '0;
      pend_ext_r  <= '0;
      await_r     <= 1'b0;
      valid_r     <= '0;
    end else begin
      if (cfg_we) pc_r <= cfg_data;
      else if (commit) pc_r <= pc_nxt;
      if (rf_we) valid_r[rf_waddr] <= 1'b1;
      if (commit && set_pend) begin
        pend_dest_r <= set_dest;
        pend_ext_r  <= set_ext;
        await_r     <= 1'b1;
      end else if (commit && clr_pend) begin
        await_r <= 1'b0;
      end
    end
  end

  assign res = res_r;

  // x0 is never written.
  a_x0: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r[0]) else $error("x0 marked written");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_fin |-> dv_cnt_r == 6'd32) else $error("divider finished early");
  a_one_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.exec && cmd.div_fin)) else $error("double commit");
endmodule

@@ sim/rv32im_exec_checker.sv @@
// Checker for the RV32IM execute unit: predicts every result beat and compares it.
// Depends on rv32_exec_pkg; watches the channel signals of the testbench top.
`timescale 1ns / 1ps
module rv32im_exec_checker
  import rv32_exec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  item_t       in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  result_t     out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          outstanding
);

  logic [31:0] gpr [32];
  logic [31:0] cur_pc;
  logic [4:0]  load_dest;
  logic [2:0]  load_ext;
  logic        load_waiting;
  result_t     expected_q [$];

  function automatic logic [31:0] read_gpr(logic [4:0] idx);
    return (idx == 5'd0) ? 32'd0 : gpr[idx];
  endfunction

  function automatic void write_gpr(logic [4:0] idx, logic [31:0] val);
    if (idx != 5'd0) gpr[idx] = val;
  endfunction

  function automatic logic signed_lt(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // Integer, shift and multiply/divide result; returns 0 for an undefined encoding.
  function automatic logic alu_calc(logic [2:0] f3, logic [6:0] f7, logic [31:0] a,
                                    logic [31:0] b, logic is_imm, output logic [31:0] r);
    logic [63:0] sa, sb, prod;
    sa = {{32{a[31]}}, a};
    sb = {{32{b[31]}}, b};
    r = 32'd0;
    if (!is_imm && f7 == F7_MULD) begin
      case (f3)
        3'd0: r = a * b;
        3'd1: begin prod = sa * sb; r = prod[63:32]; end
        3'd2: begin prod = sa * {32'd0, b}; r = prod[63:32]; end
        3'd3: begin prod = {32'd0, a} * {32'd0, b}; r = prod[63:32]; end
        3'd4: begin
          if (b == 0) r = '1;
          else if (a == 32'h8000_0000 && b == '1) r = 32'h8000_0000;
          else r = $signed(a) / $signed(b);
        end
        3'd5: r = (b == 0) ? '1 : a / b;
        3'd6: begin
          if (b == 0) r = a;
          else if (a == 32'h8000_0000 && b == '1) r = 32'd0;
          else r = $signed(a) % $signed(b);
        end
        default: r = (b == 0) ? a : a % b;
      endcase
      return 1'b1;
    end
    if (f3 == 3'd1) begin
      if (f7 != F7_ZERO) return 1'b0;
      r = a << b[4:0];
      return 1'b1;
    end
    if (f3 == 3'd5) begin
      if (f7 == F7_ZERO) r = a >> b[4:0];
      else if (f7 == F7_ALT) r = $signed(a) >>> b[4:0];
      else return 1'b0;
      return 1'b1;
    end
    if (!is_imm && !(f7 == F7_ZERO || (f7 == F7_ALT && f3 == 3'd0))) return 1'b0;
    case (f3)
      3'd0: r = (!is_imm && f7 == F7_ALT) ? a - b : a + b;
      3'd2: r = {31'd0, signed_lt(a, b)};
      3'd3: r = {31'd0, a < b};
      3'd4: r = a ^ b;
      3'd6: r = a | b;
      default: r = a & b;
    endcase
    return 1'b1;
  endfunction

  // Executes one beat on the shadow state and returns the result it must cause.
  function automatic result_t execute_beat(item_t it);
    result_t res;
    logic [31:0] w, a, b, immi, npc, r, off, v;
    logic [4:0] rd;
    logic [2:0] f3;
    logic [6:0] f7;
    logic take;
    res = '0;
    res.outcome = OC_RETIRED;
    if (it.mode) begin
      res.next_pc = cur_pc;
      if (!load_waiting) begin
        res.outcome = OC_ILLEGAL;
        return res;
      end
      w = it.response_data;
      case (load_ext)
        3'd0: v = {{24{w[7]}}, w[7:0]};
        3'd1: v = {{16{w[15]}}, w[15:0]};
        3'd4: v = {24'd0, w[7:0]};
        3'd5: v = {16'd0, w[15:0]};
        default: v = w;
      endcase
      write_gpr(load_dest, v);
      load_waiting = 1'b0;
      res.outcome = OC_RESPONSE;
      return res;
    end
    w = it.instruction;
    rd = w[11:7];
    f3 = w[14:12];
    f7 = w[31:25];
    a = read_gpr(w[19:15]);
    b = read_gpr(w[24:20]);
    immi = {{20{w[31]}}, w[31:20]};
    npc = cur_pc + 4;
    res.next_pc = cur_pc;
    case (w[6:0])
      OP_SYSTEM: begin
        res.outcome = OC_ECALL;
        res.ecall_code = read_gpr(REG_A7);
        res.ecall_arg = read_gpr(REG_A0);
        if (res.ecall_code == SVC_GETCHAR) begin
          load_dest = REG_A0;
          load_ext = EXT_WORD;
          load_waiting = 1'b1;
          cur_pc = npc;
        end else if (res.ecall_code == SVC_PUTCHAR) begin
          cur_pc = npc;
        end
        res.next_pc = cur_pc;
        return res;
      end
      OP_LUI: write_gpr(rd, {w[31:12], 12'd0});
      OP_AUIPC: write_gpr(rd, cur_pc + {w[31:12], 12'd0});
      OP_JAL: begin
        off = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        write_gpr(rd, npc);
        npc = cur_pc + off;
      end
      OP_JALR: begin
        r = (a + immi) & ~32'd1;
        write_gpr(rd, npc);
        npc = r;
      end
      OP_BRANCH: begin
        off = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        case (f3)
          3'd0: take = (a == b);
          3'd1: take = (a != b);
          3'd4: take = signed_lt(a, b);
          3'd5: take = !signed_lt(a, b);
          3'd6: take = (a < b);
          3'd7: take = (a >= b);
          default: begin
            res.outcome = OC_ILLEGAL;
            return res;
          end
        endcase
        if (take) npc = cur_pc + off;
      end
      OP_LOAD: begin
        if (f3 == 3'd3 || f3 >= 3'd6) begin
          res.outcome = OC_ILLEGAL;
          return res;
        end
        load_dest = rd;
        load_ext = f3;
        load_waiting = 1'b1;
        cur_pc = npc;
        res.outcome = OC_LOAD;
        res.mem_address = a + immi;
        res.access_size = f3[1:0];
        res.next_pc = cur_pc;
        return res;
      end
      OP_STORE: begin
        if (f3 > 3'd2) begin
          res.outcome = OC_ILLEGAL;
          return res;
        end
        off = {{20{w[31]}}, w[31:25], w[11:7]};
        v = b;
        if (f3 == 3'd0) v = v & 32'hFF;
        else if (f3 == 3'd1) v = v & 32'hFFFF;
        cur_pc = npc;
        res.outcome = OC_STORE;
        res.mem_address = a + off;
        res.store_value = v;
        res.access_size = f3[1:0];
        res.next_pc = cur_pc;
        return res;
      end
      OP_IMM: begin
        if (f3 == 3'd1 || f3 == 3'd5) take = alu_calc(f3, f7, a, {27'd0, w[24:20]}, 1'b1, r);
        else take = alu_calc(f3, F7_ZERO, a, immi, 1'b1, r);
        if (!take) begin
          res.outcome = OC_ILLEGAL;
          return res;
        end
        write_gpr(rd, r);
      end
      OP_REG: begin
        if (!alu_calc(f3, f7, a, b, 1'b0, r)) begin
          res.outcome = OC_ILLEGAL;
          return res;
        end
        write_gpr(rd, r);
      end
      default: begin
        res.outcome = OC_ILLEGAL;
        return res;
      end
    endcase
    cur_pc = npc;
    res.next_pc = cur_pc;
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Track configuration and input beats, then compare every result beat.
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst_n) begin
      foreach (gpr[i]) gpr[i] = 32'd0;
      cur_pc = 32'd0;
      load_dest = 5'd0;
      load_ext = 3'd0;
      load_waiting = 1'b0;
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) cur_pc = cfg_data;
      if (in_valid && in_ready) expected_q.push_back(execute_beat(in_data));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no expectation waiting");
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("outcome", exp_r.outcome, out_data.outcome);
          check_field("mem_address", exp_r.mem_address, out_data.mem_address);
          check_field("store_value", exp_r.store_value, out_data.store_value);
          check_field("access_size", exp_r.access_size, out_data.access_size);
          check_field("next_pc", exp_r.next_pc, out_data.next_pc);
          check_field("ecall_code", exp_r.ecall_code, out_data.ecall_code);
          check_field("ecall_arg", exp_r.ecall_arg, out_data.ecall_arg);
        end
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

@@ sim/rv32im_instruction_execute_unit_test.sv @@
// Testbench top for the RV32IM execute unit: clock, reset, stimulus and verdict.
// Depends on rv32_exec_pkg, rv32_exec_if, the unit itself and rv32im_exec_checker.
`timescale 1ns / 1ps
module rv32im_instruction_execute_unit_test;
  import rv32_exec_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic clk;
  logic rst_n;
  logic quiet;
  int   fail_count;
  int   outstanding;
  int   idle_cycles = 0;

  rv32_exec_if #(.T(item_t))       in_if ();
  rv32_exec_if #(.T(result_t))     out_if ();
  rv32_exec_if #(.T(logic [31:0])) cfg_if ();

  rv32im_instruction_execute_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source),
    .cfg_ch (cfg_if.sink)
  );

  rv32im_exec_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_if.valid),
    .in_ready    (in_if.ready),
    .in_data     (in_if.data),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .out_data    (out_if.data),
    .cfg_valid   (cfg_if.valid),
    .cfg_ready   (cfg_if.ready),
    .cfg_data    (cfg_if.data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side stalls now and then, except during the quiet stretch.
  always @(posedge clk) begin
    out_if.ready <= quiet || ($urandom_range(99) >= 6);
  end

  // Watchdog on cycles without any beat.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [6:0] op);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], op};
  endfunction

  // Mostly a small set of registers so results feed later instructions.
  function automatic logic [4:0] pick_reg();
    logic [4:0] hot [8] = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd5, 5'd10, 5'd17, 5'd31};
    if ($urandom_range(3) == 0) return 5'($urandom);
    return hot[$urandom_range(7)];
  endfunction

  task automatic send_beat(logic mode, logic [31:0] word, logic [31:0] resp);
    item_t it;
    it.mode = mode;
    it.instruction = word;
    it.response_data = resp;
    if (!quiet && $urandom_range(99) < 6) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic send_instr(logic [31:0] word);
    send_beat(1'b0, word, 32'($urandom));
  endtask

  task automatic send_resp(logic [31:0] data);
    send_beat(1'b1, 32'($urandom), data);
  endtask

  // Holds off the sender until every result has arrived.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_start(logic [31:0] addr);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= addr;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // One random instruction, sometimes a short sequence around it.
  task automatic random_instr();
    logic [31:0] w;
    logic [2:0]  f3;
    logic [6:0]  f7;
    int          pick;
    logic [31:0] svc [4] = '{32'd1, 32'd2, 32'd93, 32'd0};
    pick = $urandom_range(99);
    f3 = 3'($urandom);
    w = 32'($urandom);
    if (pick < 10) begin
      send_instr({w[31:12], pick_reg(), (w[0] ? OP_LUI : OP_AUIPC)});
    end else if (pick < 20) begin
      send_instr(enc_i(w[31:20], pick_reg(), 3'd0, pick_reg(), OP_IMM));
    end else if (pick < 24) begin
      send_instr({w[31:12], pick_reg(), OP_JAL});
    end else if (pick < 28) begin
      send_instr(enc_i(w[31:20], pick_reg(), f3, pick_reg(), OP_JALR));
    end else if (pick < 36) begin
      send_instr(enc_s(w[31:20], pick_reg(), pick_reg(), f3, OP_BRANCH));
    end else if (pick < 46) begin
      send_instr(enc_i(w[31:20], pick_reg(), f3, pick_reg(), OP_LOAD));
      if ($urandom_range(9) < 8) send_resp(32'($urandom));
    end else if (pick < 53) begin
      send_instr(enc_s(w[31:20], pick_reg(), pick_reg(), 3'($urandom_range(3)), OP_STORE));
    end else if (pick < 65) begin
      f7 = ($urandom_range(4) == 0) ? 7'($urandom) : (w[1] ? F7_ALT : F7_ZERO);
      send_instr({f7, pick_reg(), pick_reg(), f3, pick_reg(), OP_IMM});
    end else if (pick < 88) begin
      case ($urandom_range(5))
        0, 1: f7 = F7_MULD;
        2: f7 = F7_ALT;
        3: f7 = 7'($urandom);
        default: f7 = F7_ZERO;
      endcase
      send_instr(enc_r(f7, pick_reg(), pick_reg(), f3, pick_reg(), OP_REG));
    end else if (pick < 94) begin
      if ($urandom_range(3) != 0)
        send_instr(enc_i(svc[$urandom_range(3)][11:0], 5'd0, 3'd0, REG_A7, OP_IMM));
      send_instr({w[31:7], OP_SYSTEM});
      if ($urandom_range(9) < 7) send_resp(32'($urandom));
    end else if (pick < 97) begin
      send_resp(32'($urandom));
    end else begin
      send_instr(w);
    end
  endtask

  initial begin
    logic [31:0] starts [3];
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    quiet = 1'b0;
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: division corners, multiply high, shifts, loads, stores, branches, jumps, ecalls.
    write_start(32'd0);
    send_instr({20'h80000, 5'd1, OP_LUI});
    send_instr(enc_i(12'hFFF, 5'd0, 3'd0, 5'd2, OP_IMM));
    send_instr(enc_r(F7_MULD, 5'd2, 5'd1, 3'd4, 5'd4, OP_REG));
    send_instr(enc_r(F7_MULD, 5'd2, 5'd1, 3'd6, 5'd5, OP_REG));
    send_instr(enc_r(F7_MULD, 5'd3, 5'd1, 3'd5, 5'd6, OP_REG));
    send_instr(enc_r(F7_MULD, 5'd3, 5'd1, 3'd6, 5'd7, OP_REG));
    send_instr(enc_r(F7_MULD, 5'd2, 5'd1, 3'd1, 5'd8, OP_REG));
    send_instr(enc_r(F7_MULD, 5'd2, 5'd1, 3'd2, 5'd9, OP_REG));
    send_instr(enc_r(F7_MULD, 5'd2, 5'd2, 3'd3, 5'd8, OP_REG));
    send_instr(enc_r(F7_ALT, 5'd2, 5'd1, 3'd5, 5'd10, OP_REG));
    send_instr({F7_ALT, 5'd31, 5'd1, 3'd5, 5'd11, OP_IMM});
    send_instr({F7_ALT, 5'd3, 5'd1, 3'd1, 5'd11, OP_IMM});
    send_instr(enc_i(12'h000, 5'd2, 3'd0, 5'd12, OP_LOAD));
    send_resp(32'h0000_0080);
    send_instr(enc_i(12'h7FF, 5'd1, 3'd5, 5'd13, OP_LOAD));
    send_resp(32'hFFFF_8001);
    send_instr(enc_i(12'h000, 5'd1, 3'd3, 5'd13, OP_LOAD));
    send_instr(enc_i(12'h800, 5'd0, 3'd2, 5'd0, OP_LOAD));
    send_resp(32'hFFFF_FFFF);
    send_instr(enc_s(12'h800, 5'd2, 5'd1, 3'd0, OP_STORE));
    send_instr(enc_s(12'hFFC, 5'd2, 5'd1, 3'd2, OP_STORE));
    send_instr(enc_s(12'hFFE, 5'd1, 5'd2, 3'd4, OP_BRANCH));
    send_instr(enc_s(12'h010, 5'd1, 5'd2, 3'd2, OP_BRANCH));
    send_instr(enc_i(12'h003, 5'd2, 3'd0, 5'd1, OP_JALR));
    send_instr({20'h80000, 5'd3, OP_JAL});
    send_instr(enc_i(12'd1, 5'd0, 3'd0, REG_A7, OP_IMM));
    send_instr({25'd0, OP_SYSTEM});
    send_resp(32'hA5A5_5A5A);
    send_resp(32'h1234_5678);
    send_instr(enc_i(12'd2, 5'd0, 3'd0, REG_A7, OP_IMM));
    send_instr({25'd0, OP_SYSTEM});
    send_instr(enc_i(12'd93, 5'd0, 3'd0, REG_A7, OP_IMM));
    send_instr({25'd0, OP_SYSTEM});
    send_instr(32'hFFFF_FFFF);
    drain();

    // Random part in three phases, each with its own start address.
    starts[0] = 32'hFFFF_FFFF;
    starts[1] = 32'($urandom);
    starts[2] = 32'hFFFF_FFFC;
    for (int ph = 0; ph < 3; ph++) begin
      write_start(starts[ph]);
      for (int n = 0; n < 210; n++) begin
        quiet = (ph == 1 && n >= 60 && n < 180);
        random_instr();
      end
      quiet = 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ rv32im_instruction_execute_unit.f @@
src/rv32_exec_pkg.sv
src/rv32_exec_if.sv
src/rv32_ram.sv
src/rv32_exec_ctrl.sv
src/rv32_exec_dp.sv
src/rv32im_instruction_execute_unit.sv
sim/rv32im_exec_checker.sv
sim/rv32im_instruction_execute_unit_test.sv
